@@ hw/rtl/mandelbrot_escape_time_color_macros.svh @@
// Assertion macros shared by the escape-time color block.
`ifndef MANDELBROT_ESCAPE_TIME_COLOR_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_COLOR_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MEC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MEC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/mec_pkg.sv @@
// Shared types, constants and saturation helper for the escape-time color block.
`timescale 1ns / 1ps

package mec_pkg;

   localparam int MUL_W = 33;

   typedef logic signed [MUL_W-1:0]   mul_op_type;
   typedef logic signed [2*MUL_W-1:0] mul_prod_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_ITER_LIMIT = 3'd0;
   localparam logic [2:0] CSR_RADIUS     = 3'd1;
   localparam logic [2:0] CSR_STEP       = 3'd2;
   localparam logic [2:0] CSR_REAL       = 3'd3;
   localparam logic [2:0] CSR_IMAG       = 3'd4;

   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

   // Color scale factors: 9*255, 15*255 and 17*255 (blue is halved by its shift).
   localparam logic [31:0] RED_SCALE   = 32'd2295;
   localparam logic [31:0] GREEN_SCALE = 32'd3825;
   localparam logic [31:0] BLUE_SCALE  = 32'd4335;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/mec_mul.sv @@
// Shared signed 33x33 multiplier with a registered product.
`timescale 1ns / 1ps

module mec_mul
   import mec_pkg::*;
(
   input  logic         clock,
   input  mul_op_type   mul_a,
   input  mul_op_type   mul_b,
   output mul_prod_type mul_p
);

   mul_prod_type p_ff;

   always_ff @(posedge clock) begin
      p_ff <= mul_prod_type'(mul_a) * mul_prod_type'(mul_b);
   end

   assign mul_p = p_ff;

endmodule

@@ hw/rtl/mandelbrot_escape_time_color.sv @@
// Top level of the Mandelbrot escape-time pixel evaluator with color mapping.
`timescale 1ns / 1ps

// Each req item names one pixel (column, row). The block maps it to the point c in
// signed Q4.28, iterates z = z*z + c from z = c until the squared magnitude exceeds
// the squared escape radius or the count reaches the iteration limit, and returns one
// rsp item with the count and an RGB color. All products run through a single
// registered 33x33 multiplier. After acceptance an item passes through setup, the
// iterations, the final escape test or limit check, the ratio division (one quotient
// bit per cycle), the square root (one result bit per cycle), the color products and
// the hand-over of the result, and then returns to idle. The default limit is 256.
// req_tready is high only while no pixel is being worked on; a finished result sits
// in the output register and the next pixel can be accepted while it waits, but that
// pixel holds at its hand-over step until the register is free. A limit of zero
// returns count zero and black without the division, root or color steps. Columns
// and rows beyond the image clamp to its last index. Configuration must be written
// through csr_we/csr_index/csr_wdata only while the block is idle; the block itself
// does not enforce this. Indexes outside the register list are ignored.

`include "mandelbrot_escape_time_color_macros.svh"

module mandelbrot_escape_time_color
   import mec_pkg::*;
#(
   parameter int MAX_COLUMNS = 4096,
   parameter int MAX_ROWS    = 4096
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // column [11:0], row [23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // iteration_count [15:0], red [23:16],
                                    // green [31:24], blue [39:32]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_ITER  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_SQRT  = 3'd4;
   localparam logic [2:0] S_COLOR = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // Configuration registers.
   logic [15:0]        iter_limit_ff;
   logic [30:0]        radius_ff;
   logic [30:0]        step_ff;
   logic signed [31:0] real_org_ff;
   logic signed [31:0] imag_org_ff;

   // Sequencer.
   logic [2:0] state_ff, state_in;
   logic [5:0] op_ff, op_in;

   // Working registers.
   logic [11:0]        col_ff, col_in;
   logic [11:0]        row_ff, row_in;
   logic signed [31:0] cre_ff, cre_in;
   logic signed [31:0] cim_ff, cim_in;
   logic signed [31:0] zre_ff, zre_in;
   logic signed [31:0] zim_ff, zim_in;
   logic [61:0]        r2_ff, r2_in;
   logic [63:0]        sqre_ff, sqre_in;
   logic [63:0]        sqim_ff, sqim_in;
   logic [15:0]        count_ff, count_in;
   logic [16:0]        rem_ff, rem_in;
   logic [32:0]        quo_ff, quo_in;
   logic [32:0]        sq_v_ff, sq_v_in;
   logic [33:0]        sq_res_ff, sq_res_in;
   logic [32:0]        sq_bit_ff, sq_bit_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        b_ff, b_in;
   logic [31:0]        c_ff, c_in;
   logic [31:0]        pr_ff, pr_in;
   logic [31:0]        pg_ff, pg_in;
   logic [31:0]        pb_ff, pb_in;
   logic [7:0]         red_ff, red_in;
   logic [7:0]         green_ff, green_in;
   logic [7:0]         blue_ff, blue_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   // Multiplier and datapath temporaries.
   mul_op_type         mul_a, mul_b;
   mul_prod_type       mul_p;
   logic [63:0]        mag;
   logic               escaped;
   logic signed [63:0] diff;
   logic signed [63:0] xprod;
   logic [16:0]        div_t;
   logic [33:0]        sq_trial;
   logic [16:0]        k_val;
   logic [16:0]        kc_val;

   mec_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign k_val  = sq_res_ff[16:0];
   assign kc_val = 17'h1_0000 - k_val;

   // Operand selection for the shared multiplier. A product issued at op i is
   // read back at op i+1.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SETUP: begin
            case (op_ff)
               6'd0: begin
                  mul_a = mul_op_type'({21'b0, col_ff});
                  mul_b = mul_op_type'({2'b0, step_ff});
               end
               6'd1: begin
                  mul_a = mul_op_type'({21'b0, row_ff});
                  mul_b = mul_op_type'({2'b0, step_ff});
               end
               6'd2: begin
                  mul_a = mul_op_type'({2'b0, radius_ff});
                  mul_b = mul_op_type'({2'b0, radius_ff});
               end
               default: ;
            endcase
         end
         S_ITER: begin
            case (op_ff)
               6'd0: begin
                  mul_a = mul_op_type'(zre_ff);
                  mul_b = mul_op_type'(zre_ff);
               end
               6'd1: begin
                  mul_a = mul_op_type'(zim_ff);
                  mul_b = mul_op_type'(zim_ff);
               end
               6'd2: begin
                  mul_a = mul_op_type'(zre_ff);
                  mul_b = mul_op_type'(zim_ff);
               end
               default: ;
            endcase
         end
         S_COLOR: begin
            case (op_ff)
               6'd0: begin
                  mul_a = mul_op_type'({16'b0, k_val});
                  mul_b = mul_op_type'({16'b0, k_val});
               end
               6'd1: begin
                  mul_a = mul_op_type'({16'b0, kc_val});
                  mul_b = mul_op_type'({16'b0, k_val});
               end
               6'd2: begin
                  mul_a = mul_op_type'({16'b0, kc_val});
                  mul_b = mul_op_type'({16'b0, kc_val});
               end
               6'd3: begin
                  mul_a = mul_op_type'({1'b0, b_ff});
                  mul_b = mul_op_type'({1'b0, a_ff});
               end
               6'd4: begin
                  mul_a = mul_op_type'({1'b0, c_ff});
                  mul_b = mul_op_type'({1'b0, a_ff});
               end
               6'd5: begin
                  mul_a = mul_op_type'({1'b0, c_ff});
                  mul_b = mul_op_type'({1'b0, b_ff});
               end
               6'd6: begin
                  mul_a = mul_op_type'({1'b0, RED_SCALE});
                  mul_b = mul_op_type'({1'b0, pr_ff});
               end
               6'd7: begin
                  mul_a = mul_op_type'({1'b0, GREEN_SCALE});
                  mul_b = mul_op_type'({1'b0, pg_ff});
               end
               6'd8: begin
                  mul_a = mul_op_type'({1'b0, BLUE_SCALE});
                  mul_b = mul_op_type'({1'b0, pb_ff});
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign mag      = sqre_ff + sqim_ff;
   assign escaped  = mag > {2'b0, r2_ff};
   assign diff     = signed'(sqre_ff - sqim_ff);
   assign xprod    = mul_p[63:0];
   assign div_t    = (op_ff == 6'd0) ? rem_ff : {rem_ff[15:0], 1'b0};
   assign sq_trial = sq_res_ff + {1'b0, sq_bit_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      zre_in       = zre_ff;
      zim_in       = zim_ff;
      r2_in        = r2_ff;
      sqre_in      = sqre_ff;
      sqim_in      = sqim_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      pr_in        = pr_ff;
      pg_in        = pg_ff;
      pb_in        = pb_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               col_in = (32'(req_tdata[11:0]) >= 32'(MAX_COLUMNS)) ?
                        12'(MAX_COLUMNS - 1) : req_tdata[11:0];
               row_in = (32'(req_tdata[23:12]) >= 32'(MAX_ROWS)) ?
                        12'(MAX_ROWS - 1) : req_tdata[23:12];
               state_in = S_SETUP;
               op_in    = 6'd0;
            end
         end
         S_SETUP: begin
            op_in = op_ff + 6'd1;
            case (op_ff)
               6'd1: begin
                  cre_in = sat32(64'(real_org_ff) + signed'(64'(mul_p[42:0])));
                  zre_in = sat32(64'(real_org_ff) + signed'(64'(mul_p[42:0])));
               end
               6'd2: begin
                  cim_in = sat32(64'(imag_org_ff) + signed'(64'(mul_p[42:0])));
                  zim_in = sat32(64'(imag_org_ff) + signed'(64'(mul_p[42:0])));
               end
               6'd3: begin
                  r2_in    = mul_p[61:0];
                  count_in = '0;
                  state_in = S_ITER;
                  op_in    = 6'd0;
               end
               default: ;
            endcase
         end
         S_ITER: begin
            op_in = op_ff + 6'd1;
            case (op_ff)
               6'd0: begin
                  if (count_ff == iter_limit_ff) begin
                     if (iter_limit_ff == 16'd0) begin
                        // A zero limit yields black without any color math.
                        red_in   = '0;
                        green_in = '0;
                        blue_in  = '0;
                        state_in = S_DONE;
                     end else begin
                        rem_in   = {1'b0, count_ff};
                        quo_in   = '0;
                        state_in = S_DIV;
                        op_in    = 6'd0;
                     end
                  end
               end
               6'd1: sqre_in = mul_p[63:0];
               6'd2: sqim_in = mul_p[63:0];
               6'd3: begin
                  op_in = 6'd0;
                  if (escaped) begin
                     rem_in   = {1'b0, count_ff};
                     quo_in   = '0;
                     state_in = S_DIV;
                  end else begin
                     count_in = count_ff + 16'd1;
                     zre_in   = sat32((diff >>> 28) + 64'(cre_ff));
                     zim_in   = sat32((xprod >>> 27) + 64'(cim_ff));
                  end
               end
               default: ;
            endcase
         end
         S_DIV: begin
            // Restoring division of count * 2^32 by the limit, one bit a cycle.
            op_in = op_ff + 6'd1;
            if (div_t >= {1'b0, iter_limit_ff}) begin
               rem_in = div_t - {1'b0, iter_limit_ff};
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = div_t;
               quo_in = {quo_ff[31:0], 1'b0};
            end
            if (op_ff == 6'd32) begin
               state_in = S_SQRT;
               op_in    = 6'd0;
            end
         end
         S_SQRT: begin
            op_in = op_ff + 6'd1;
            if (op_ff == 6'd0) begin
               sq_v_in   = quo_ff;
               sq_res_in = '0;
               sq_bit_in = 33'h1_0000_0000;
            end else begin
               if ({1'b0, sq_v_ff} >= sq_trial) begin
                  sq_v_in   = 33'({1'b0, sq_v_ff} - sq_trial);
                  sq_res_in = (sq_res_ff >> 1) + {1'b0, sq_bit_ff};
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
               if (op_ff == 6'd17) begin
                  state_in = S_COLOR;
                  op_in    = 6'd0;
               end
            end
         end
         S_COLOR: begin
            op_in = op_ff + 6'd1;
            case (op_ff)
               6'd1: a_in     = mul_p[31:0];
               6'd2: b_in     = mul_p[31:0];
               6'd3: c_in     = mul_p[31:0];
               6'd4: pr_in    = mul_p[63:32];
               6'd5: pg_in    = mul_p[63:32];
               6'd6: pb_in    = mul_p[63:32];
               6'd7: red_in   = mul_p[39:32];
               6'd8: green_in = mul_p[39:32];
               6'd9: begin
                  blue_in  = mul_p[40:33];
                  state_in = S_DONE;
               end
               default: ;
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {blue_ff, green_ff, red_ff, count_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         iter_limit_ff <= 16'd256;
         radius_ff     <= 31'h2000_0000;
         step_ff       <= 31'h0010_0000;
         real_org_ff   <= 32'shE000_0000;
         imag_org_ff   <= 32'shF000_0000;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[15:0];
               CSR_RADIUS:     radius_ff     <= csr_wdata[30:0];
               CSR_STEP:       step_ff       <= csr_wdata[30:0];
               CSR_REAL:       real_org_ff   <= signed'(csr_wdata);
               CSR_IMAG:       imag_org_ff   <= signed'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      zre_ff      <= zre_in;
      zim_ff      <= zim_in;
      r2_ff       <= r2_in;
      sqre_ff     <= sqre_in;
      sqim_ff     <= sqim_in;
      count_ff    <= count_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      pr_ff       <= pr_in;
      pg_ff       <= pg_in;
      pb_ff       <= pb_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MEC_ASSERT_IMP(a_count_in_limit, clock, reset, state_ff == S_ITER, count_ff <= iter_limit_ff, "iteration count passed the limit")
   `MEC_ASSERT_NXT(a_accept_starts_setup, clock, reset, req_tvalid && req_tready, state_ff == S_SETUP && op_ff == 6'd0, "accepted item did not start setup")
   `MEC_ASSERT_IMP(a_ratio_in_range, clock, reset, state_ff == S_SQRT && op_ff == 6'd0, quo_ff <= 33'h1_0000_0000, "ratio above one")
   `MEC_ASSERT_IMP(a_root_in_range, clock, reset, state_ff == S_COLOR, sq_res_ff <= 34'd65536, "square root above one")

endmodule
